[design/b2s_pkg.sv]
// ----------------------------------------------------------------------------
// b2s_pkg
// Types, constants and tables shared by the BLAKE2s hash engine modules.
// ----------------------------------------------------------------------------
package b2s_pkg;

  localparam int Rounds = 10;

  localparam logic [31:0] ParamBase = 32'h0101_0000;

  localparam logic [31:0] IV [8] = '{
    32'h6A09_E667, 32'hBB67_AE85, 32'h3C6E_F372, 32'hA54F_F53A,
    32'h510E_527F, 32'h9B05_688C, 32'h1F83_D9AB, 32'h5BE0_CD19
  };

  localparam logic [3:0] SIGMA [Rounds][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // configuration register indexes
  localparam logic [2:0] RegDigestLen = 3'd0;
  localparam logic [2:0] RegKeyLen    = 3'd1;
  localparam logic [2:0] RegKey0      = 3'd2;
  localparam logic [2:0] RegKey1      = 3'd3;
  localparam logic [2:0] RegKey2      = 3'd4;
  localparam logic [2:0] RegKey3      = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_CHECK, ST_ROUND, ST_FOLD, ST_WRITE, ST_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;   // latch the accepted item
    logic start;     // open a message
    logic init;      // load working vector
    logic final_blk; // final flag for init
    logic step;      // one half-G step on all four lanes
    logic fold;      // fold working vector into chain
    logic clear;     // empty the block buffer after a middle compression
    logic write;     // store the held word
    logic emit;      // advance the digest word on a transfer
    logic close;     // end of message
  } cmd_t;

  typedef struct packed {
    logic open;
    logic full;
    logic has_bytes;
    logic is_last;
    logic round_done;
    logic last_out;
  } status_t;

  function automatic logic [31:0] byte_mask(input logic [5:0] n);
    logic [31:0] m;
    case (n)
      6'd0:    m = 32'h0000_0000;
      6'd1:    m = 32'h0000_00FF;
      6'd2:    m = 32'h0000_FFFF;
      6'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

[design/b2s_ctrl.sv]
// ----------------------------------------------------------------------------
// b2s_ctrl
// Sequencer for the hash engine: item intake, compressions and digest output.
// ----------------------------------------------------------------------------
module b2s_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  b2s_pkg::status_t sts,
  output b2s_pkg::cmd_t    cmd
);
  import b2s_pkg::*;

  state_t state_r, state_nxt;
  logic   final_r, final_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.open ? ST_CHECK : ST_START;
        end
      end
      ST_START: state_nxt = ST_CHECK;
      ST_CHECK: begin
        // a full buffer is compressed only once more bytes arrive
        if (sts.has_bytes && sts.full) begin
          state_nxt = ST_ROUND;
          final_nxt = 1'b0;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_ROUND: begin
        if (sts.round_done) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD:  state_nxt = final_r ? ST_OUT : ST_WRITE;
      ST_WRITE: state_nxt = sts.is_last ? ST_FIN : ST_IDLE;
      ST_FIN: begin
        state_nxt = ST_ROUND;
        final_nxt = 1'b1;
      end
      ST_OUT: begin
        if (out_tready && sts.last_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_START: cmd.start = 1'b1;
      ST_CHECK: cmd.init = sts.has_bytes && sts.full;
      ST_ROUND: cmd.step = 1'b1;
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        cmd.clear = !final_r;
      end
      ST_WRITE: cmd.write = 1'b1;
      ST_FIN: begin
        cmd.init      = 1'b1;
        cmd.final_blk = 1'b1;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        cmd.emit   = out_tready;
        cmd.close  = out_tready && sts.last_out;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[design/b2s_datapath.sv]
// ----------------------------------------------------------------------------
// b2s_datapath
// Config registers, chain value, counter, block buffer and the G-function
// datapath: four lanes, half a G per cycle, 40 steps per compression.
// ----------------------------------------------------------------------------
module b2s_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  b2s_pkg::cmd_t    cmd,
  output b2s_pkg::status_t sts,
  input  logic [31:0]      in_word,
  input  logic [2:0]       in_count,
  input  logic             in_last,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  output logic [31:0]      out_word,
  output logic [2:0]       out_index,
  output logic             out_last
);
  import b2s_pkg::*;

  logic [5:0]  dlen_r, klen_r;
  logic [63:0] key_r [4];

  logic [31:0] h_r [8];
  logic [31:0] v_r [16];
  logic [31:0] v_step [16];
  logic [31:0] m_r [16];
  logic [63:0] t_r;
  logic [63:0] t_nxt;
  logic [6:0]  fill_r;
  logic        open_r;
  logic [3:0]  round_r;
  logic [1:0]  phase_r;
  logic [2:0]  k_r;

  logic [31:0] word_r;
  logic [2:0]  n_r;
  logic        last_r;

  logic [5:0]  dl_eff, kl_eff;
  logic [2:0]  nwords_m1;
  logic [31:0] param_word;
  logic [5:0]  rem;

  assign dl_eff     = (dlen_r == 6'd0) ? 6'd1 : ((dlen_r > 6'd32) ? 6'd32 : dlen_r);
  assign kl_eff     = (klen_r > 6'd32) ? 6'd32 : klen_r;
  assign param_word = ParamBase ^ {18'd0, kl_eff, 8'd0} ^ {26'd0, dl_eff};
  assign nwords_m1  = 3'((dl_eff + 6'd3) >> 2) - 3'd1;

  // counter update for the next compression
  assign t_nxt = cmd.final_blk ? (t_r + {57'd0, fill_r}) : (t_r + 64'd64);

  assign sts.open       = open_r;
  assign sts.full       = fill_r[6];
  assign sts.has_bytes  = (n_r != 3'd0);
  assign sts.is_last    = last_r;
  assign sts.round_done = (round_r == 4'(Rounds - 1)) && (phase_r == 2'd3);
  assign sts.last_out   = (k_r == nwords_m1);

  assign rem       = dl_eff - {1'b0, k_r, 2'b00};
  assign out_word  = h_r[k_r] & byte_mask(rem);
  assign out_index = k_r;
  assign out_last  = (k_r == nwords_m1);

  function automatic logic [127:0] half_g(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d,
                                          input logic [31:0] x, input logic second);
    logic [31:0] na, nb, nc, nd;
    na = a + b + x;
    nd = d ^ na;
    nd = second ? {nd[7:0], nd[31:8]} : {nd[15:0], nd[31:16]};
    nc = c + nd;
    nb = b ^ nc;
    nb = second ? {nb[6:0], nb[31:7]} : {nb[11:0], nb[31:12]};
    return {na, nb, nc, nd};
  endfunction

  always_comb begin
    logic [3:0]   ai, bi, ci, di;
    logic [3:0]   sel;
    logic [127:0] res;
    logic [1:0]   s;
    v_step = v_r;
    s = {1'b0, phase_r[1]};
    for (int i = 0; i < 4; i++) begin
      ai  = 4'(i);
      bi  = {2'b01, 2'(i + 32'(s))};
      ci  = {2'b10, 2'(i + 2 * 32'(s))};
      di  = {2'b11, 2'(i + 3 * 32'(s))};
      sel = SIGMA[round_r][{phase_r[1], 2'(i), phase_r[0]}];
      res = half_g(v_r[ai], v_r[bi], v_r[ci], v_r[di], m_r[sel], phase_r[0]);
      v_step[ai] = res[127:96];
      v_step[bi] = res[95:64];
      v_step[ci] = res[63:32];
      v_step[di] = res[31:0];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlen_r <= 6'd32;
      klen_r <= 6'd0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegDigestLen: dlen_r   <= cfg_data[5:0];
        RegKeyLen:    klen_r   <= cfg_data[5:0];
        RegKey0:      key_r[0] <= cfg_data;
        RegKey1:      key_r[1] <= cfg_data;
        RegKey2:      key_r[2] <= cfg_data;
        RegKey3:      key_r[3] <= cfg_data;
        default:      dlen_r   <= dlen_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      fill_r  <= '0;
      round_r <= '0;
      phase_r <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.start) begin
        open_r <= 1'b1;
        fill_r <= (kl_eff != 6'd0) ? 7'd64 : 7'd0;
      end else if (cmd.clear) begin
        fill_r <= '0;
      end else if (cmd.write && (n_r != 3'd0)) begin
        fill_r <= fill_r + {4'd0, n_r};
      end
      if (cmd.close) begin
        open_r <= 1'b0;
      end
      if (cmd.init) begin
        round_r <= '0;
        phase_r <= '0;
      end else if (cmd.step) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == 2'd3) round_r <= round_r + 4'd1;
      end
      if (cmd.init) begin
        k_r <= '0;
      end else if (cmd.emit) begin
        k_r <= k_r + 3'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_r <= in_word;
      last_r <= in_last;
      n_r    <= in_last ? ((in_count > 3'd4) ? 3'd4 : in_count) : 3'd4;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= (i == 0) ? (IV[0] ^ param_word) : IV[i];
      end
      t_r <= '0;
      // key words masked to the key length; an unkeyed message gets zeros
      for (int i = 0; i < 8; i++) begin
        m_r[i] <= key_r[i / 2][(i % 2) * 32 +: 32] &
                  byte_mask((kl_eff > 6'(4 * i)) ? kl_eff - 6'(4 * i) : 6'd0);
      end
      for (int i = 8; i < 16; i++) m_r[i] <= '0;
    end else if (cmd.clear) begin
      for (int i = 0; i < 16; i++) m_r[i] <= '0;
    end else if (cmd.write && (n_r != 3'd0)) begin
      m_r[fill_r[5:2]] <= word_r & byte_mask({3'd0, n_r});
    end
    if (cmd.init) begin
      t_r <= t_nxt;
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      for (int i = 0; i < 4; i++) v_r[i + 8] <= IV[i];
      v_r[12] <= IV[4] ^ t_nxt[31:0];
      v_r[13] <= IV[5] ^ t_nxt[63:32];
      v_r[14] <= cmd.final_blk ? ~IV[6] : IV[6];
      v_r[15] <= IV[7];
    end else if (cmd.step) begin
      v_r <= v_step;
    end
    if (cmd.fold) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] ^ v_r[i] ^ v_r[i + 8];
    end
  end

endmodule

[design/blake2s_hash_engine.sv]
// ----------------------------------------------------------------------------
// blake2s_hash_engine
// BLAKE2s hash engine with optional key and programmable digest length.
// ----------------------------------------------------------------------------
// Intake: a word that only fills the buffer passes capture, check and write (plus
// start on a message's first word). A compression runs init, 40 half-G steps of the
// 4-lane G unit, then fold. A new word is accepted only once the previous one is written.
// Last word: a full block is flushed first if needed; the word is written, the final
// compression runs, then one digest word per output transfer.
// Reset: synchronous active-low; clears the sequencer, message state and config registers.
module blake2s_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] msg_word, [34:32] byte_count, rest zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import b2s_pkg::*;

  cmd_t        cmd;
  status_t     sts;
  logic [31:0] dword;
  logic [2:0]  didx;

  assign cfg_ready = 1'b1;
  assign out_tdata = {5'd0, didx, dword};

  b2s_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  b2s_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_tdata[31:0]),
    .in_count  (in_tdata[34:32]),
    .in_last   (in_tlast),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_word  (dword),
    .out_index (didx),
    .out_last  (out_tlast)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while digest pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted back to back");

  a_digest_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (out_tvalid && out_tdata[34:32] != 3'd0))
    else $error("digest run broken");

endmodule
